@@ hdl/rrfc_pkg.sv @@
// Shared types and constants for the receive ring frame checker.
`default_nettype none

package rrfc_pkg;

  localparam int unsigned PAGE_W     = 8;
  localparam int unsigned COUNT_W    = 16;
  localparam int unsigned TOTAL_W    = 32;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_INDEX_W-1:0] CFG_RING_START = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_RING_STOP  = 2'd1;

  localparam logic [PAGE_W-1:0] RING_START_RESET = 8'd70;
  localparam logic [PAGE_W-1:0] RING_STOP_RESET  = 8'd128;
  localparam logic [PAGE_W-1:0] BOUNDARY_RESET   = RING_STOP_RESET - 8'd1;

  localparam logic [COUNT_W-1:0] HDR_BYTES   = 16'd4;
  localparam logic [COUNT_W-1:0] MIN_PAYLOAD = 16'd60;
  localparam logic [COUNT_W-1:0] MAX_PAYLOAD = 16'd1518;
  localparam logic [7:0]         STATUS_MASK = 8'h0f;
  localparam logic [7:0]         STATUS_OK   = 8'h01;

  typedef enum logic [2:0] {
    VERDICT_EMPTY     = 3'd0,
    VERDICT_ACCEPT    = 3'd1,
    VERDICT_NO_BUFFER = 3'd2,
    VERDICT_BAD_LEN   = 3'd3,
    VERDICT_BAD_STAT  = 3'd4,
    VERDICT_PTR_ERR   = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [PAGE_W-1:0]  write_page;
    logic [7:0]         hdr_status;
    logic [PAGE_W-1:0]  hdr_next;
    logic [COUNT_W-1:0] hdr_count;
    logic               host_buffer_free;
  } frame_in_t;

  // classified frame, passed from front to back
  typedef struct packed {
    verdict_t           verdict;
    logic [COUNT_W-1:0] frame_offset;
    logic [COUNT_W-1:0] payload_len;
    logic [PAGE_W-1:0]  new_boundary;
  } frame_rec_t;

  typedef struct packed {
    verdict_t           verdict;
    logic [COUNT_W-1:0] frame_offset;
    logic [COUNT_W-1:0] payload_len;
    logic [PAGE_W-1:0]  new_boundary;
    logic [TOTAL_W-1:0] error_total;
    logic [TOTAL_W-1:0] packet_total;
    logic [TOTAL_W-1:0] drop_total;
  } result_t;

endpackage

`default_nettype wire

@@ hdl/rrfc_front.sv @@
// Front end: ring registers, boundary page tracking and frame classification.
`default_nettype none

module rrfc_front
  import rrfc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  input  wire frame_in_t              item,
  input  wire logic                   q_full,
  output logic                        rec_valid,
  output frame_rec_t                  rec
);

  logic [PAGE_W-1:0] ring_start;
  logic [PAGE_W-1:0] ring_stop;
  logic [PAGE_W-1:0] boundary;
  logic [PAGE_W-1:0] boundary_next;

  logic [PAGE_W:0]    frame_inc;
  logic [PAGE_W-1:0]  frame_page;
  logic [PAGE_W-1:0]  next_page;
  logic signed [10:0] frame_w;
  logic signed [10:0] next_w;
  logic signed [10:0] npages;
  logic signed [10:0] exp0;
  logic signed [10:0] exp1;
  logic               ring_empty;
  logic               ptr_ok;
  logic               len_bad;
  logic               stat_ok;

  assign rec_valid = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_start <= RING_START_RESET;
      ring_stop  <= RING_STOP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_RING_START: ring_start <= cfg_data;
        CFG_RING_STOP:  ring_stop  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      boundary <= BOUNDARY_RESET;
    end else if (rec_valid) begin
      boundary <= boundary_next;
    end
  end

  always_comb begin
    frame_inc  = {1'b0, boundary} + 9'd1;
    frame_page = (frame_inc >= {1'b0, ring_stop}) ? ring_start : frame_inc[PAGE_W-1:0];
    ring_empty = (frame_page == item.write_page);

    // next-page check is done on plain integers, no wrap
    frame_w = $signed({3'b000, frame_page});
    next_w  = $signed({3'b000, item.hdr_next});
    npages  = $signed({3'b000, ring_stop}) - $signed({3'b000, ring_start});
    exp0    = frame_w + 11'sd1 + $signed({3'b000, item.hdr_count[15:8]});
    exp1    = exp0 + 11'sd1;
    ptr_ok  = (next_w == exp0) || (next_w == exp1) ||
              (next_w == exp0 - npages) || (next_w == exp1 - npages);

    len_bad = (item.hdr_count < MIN_PAYLOAD + HDR_BYTES) ||
              (item.hdr_count > MAX_PAYLOAD + HDR_BYTES);
    stat_ok = ((item.hdr_status & STATUS_MASK) == STATUS_OK);

    next_page = (item.hdr_next >= ring_stop) ? ring_start : item.hdr_next;

    rec.frame_offset = {frame_page, 8'h00};
    rec.payload_len  = (item.hdr_count < HDR_BYTES) ? '0 : item.hdr_count - HDR_BYTES;
    boundary_next    = next_page - 8'd1;

    if (ring_empty) begin
      rec.verdict      = VERDICT_EMPTY;
      rec.payload_len  = '0;
      boundary_next    = boundary;
    end else if (!ptr_ok) begin
      rec.verdict   = VERDICT_PTR_ERR;
      boundary_next = item.write_page - 8'd1;
    end else if (len_bad) begin
      rec.verdict = VERDICT_BAD_LEN;
    end else if (!stat_ok) begin
      rec.verdict = VERDICT_BAD_STAT;
    end else if (item.host_buffer_free) begin
      rec.verdict = VERDICT_ACCEPT;
    end else begin
      rec.verdict = VERDICT_NO_BUFFER;
    end
    rec.new_boundary = boundary_next;
  end

endmodule

`default_nettype wire

@@ hdl/rrfc_queue.sv @@
// Short queue of classified frames between front and back.
`default_nettype none

module rrfc_queue
  import rrfc_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr,
  input  wire frame_rec_t wr_rec,
  input  wire logic       rd,
  output logic            full,
  output logic            empty,
  output frame_rec_t      rd_rec
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  frame_rec_t        slots [DEPTH];
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;

  assign full   = (count == CW'(DEPTH));
  assign empty  = (count == '0);
  assign rd_rec = slots[head];

  always_comb begin
    count_next = count;
    if (wr && !rd) begin
      count_next = count + 1'b1;
    end else if (rd && !wr) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (wr) begin
        tail <= (tail == AW'(DEPTH - 1)) ? '0 : tail + 1'b1;
      end
      if (rd) begin
        head <= (head == AW'(DEPTH - 1)) ? '0 : head + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      slots[tail] <= wr_rec;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rrfc_back.sv @@
// Back end: saturating frame counters and the result register.
`default_nettype none

module rrfc_back
  import rrfc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_empty,
  input  wire frame_rec_t q_rec,
  output logic            q_rd,
  input  wire logic       pop,
  output logic            empty,
  output result_t         result
);

  logic                     out_valid;
  logic [COUNTER_WIDTH-1:0] error_count;
  logic [COUNTER_WIDTH-1:0] packet_count;
  logic [COUNTER_WIDTH-1:0] drop_count;
  logic [COUNTER_WIDTH-1:0] error_count_next;
  logic [COUNTER_WIDTH-1:0] packet_count_next;
  logic [COUNTER_WIDTH-1:0] drop_count_next;
  logic [TOTAL_W-1:0]       error_out;
  logic [TOTAL_W-1:0]       packet_out;
  logic [TOTAL_W-1:0]       drop_out;
  logic                     is_error;

  assign q_rd  = !q_empty && (!out_valid || pop);
  assign empty = !out_valid;

  always_comb begin
    is_error = (q_rec.verdict == VERDICT_BAD_LEN) ||
               (q_rec.verdict == VERDICT_BAD_STAT) ||
               (q_rec.verdict == VERDICT_PTR_ERR);
    error_count_next  = error_count;
    packet_count_next = packet_count;
    drop_count_next   = drop_count;
    if (is_error && error_count != '1) begin
      error_count_next = error_count + 1'b1;
    end
    if (q_rec.verdict == VERDICT_ACCEPT && packet_count != '1) begin
      packet_count_next = packet_count + 1'b1;
    end
    if (q_rec.verdict == VERDICT_NO_BUFFER && drop_count != '1) begin
      drop_count_next = drop_count + 1'b1;
    end
  end

  // reported totals are the updated counters, truncated or zero-extended to 32 bits
  generate
    if (COUNTER_WIDTH >= TOTAL_W) begin : g_wide
      assign error_out  = error_count_next[TOTAL_W-1:0];
      assign packet_out = packet_count_next[TOTAL_W-1:0];
      assign drop_out   = drop_count_next[TOTAL_W-1:0];
    end else begin : g_narrow
      assign error_out  = {{(TOTAL_W-COUNTER_WIDTH){1'b0}}, error_count_next};
      assign packet_out = {{(TOTAL_W-COUNTER_WIDTH){1'b0}}, packet_count_next};
      assign drop_out   = {{(TOTAL_W-COUNTER_WIDTH){1'b0}}, drop_count_next};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      error_count  <= '0;
      packet_count <= '0;
      drop_count   <= '0;
    end else begin
      if (q_rd) begin
        out_valid    <= 1'b1;
        error_count  <= error_count_next;
        packet_count <= packet_count_next;
        drop_count   <= drop_count_next;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      result.verdict      <= q_rec.verdict;
      result.frame_offset <= q_rec.frame_offset;
      result.payload_len  <= q_rec.payload_len;
      result.new_boundary <= q_rec.new_boundary;
      result.error_total  <= error_out;
      result.packet_total <= packet_out;
      result.drop_total   <= drop_out;
    end
  end

endmodule

`default_nettype wire

@@ hdl/rx_ring_frame_checker.sv @@
// Receive ring frame checker: top level.
//
// Input channel: a frame header item is transferred on a clock edge with
// push high and full low. Result channel: while empty is low the oldest
// result sits on result; it is transferred on an edge with pop high.
// Configuration: cfg_write with cfg_index 0 sets ring_start, index 1 sets
// ring_stop; other indexes are ignored. Write only while the block is idle.
// Each item yields exactly one result. The front end classifies the frame
// and updates the boundary page in the cycle of the transfer, so items are
// taken one per clock while full is low. Each item is written to a queue
// slot, then loaded into the result register, where the counters are
// applied, and from there it sits on the result ports.
// Sustained throughput is one item per cycle with pop held high.
// When pop stays low, the result register holds and the QUEUE_DEPTH-entry
// queue absorbs further items; full rises once the queue is full.
// Synchronous reset restores ring_start 70, ring_stop 128, boundary page
// 127, clears the counters and drops any queued or waiting results.
`default_nettype none

module rx_ring_frame_checker
  import rrfc_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 32,
  parameter int unsigned QUEUE_DEPTH   = 4
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   push,
  output logic                        full,
  input  wire frame_in_t              item,
  output logic                        empty,
  input  wire logic                   pop,
  output result_t                     result
);

  logic       rec_valid;
  frame_rec_t rec;
  logic       q_full;
  logic       q_empty;
  logic       q_rd;
  frame_rec_t q_rec;

  assign full = q_full;

  rrfc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .item      (item),
    .q_full    (q_full),
    .rec_valid (rec_valid),
    .rec       (rec)
  );

  rrfc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (rec_valid),
    .wr_rec (rec),
    .rd     (q_rd),
    .full   (q_full),
    .empty  (q_empty),
    .rd_rec (q_rec)
  );

  rrfc_back #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_rec   (q_rec),
    .q_rd    (q_rd),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

endmodule

`default_nettype wire

@@ tb/rx_ring_frame_checker_tb.sv @@
// Self-checking testbench for the receive ring frame checker.
`timescale 1ns / 1ps

module rx_ring_frame_checker_tb;
  import rrfc_pkg::*;

  localparam int STUCK_LIMIT = 500;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 75;
  localparam int PHASES      = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_3 = 2'd3;

  // stimulus row: header fields, then an optional typed-in verdict and offset
  typedef struct packed {
    frame_in_t          hdr;
    logic               pinned;
    verdict_t           verdict;
    logic [COUNT_W-1:0] offset;
  } dir_row_t;

  // walked from reset: ring 70..127, boundary 127
  localparam dir_row_t DIR_TAB [16] = '{
    {8'd70,  8'h00, 8'h00,   16'd0,    1'b0, 1'b1, VERDICT_EMPTY,     16'h4600},
    {8'd100, 8'h01, 8'd71,   16'd68,   1'b1, 1'b1, VERDICT_ACCEPT,    16'h4600},
    {8'd100, 8'hF1, 8'd72,   16'd64,   1'b0, 1'b1, VERDICT_NO_BUFFER, 16'h4700},
    {8'd100, 8'h01, 8'd79,   16'd1522, 1'b1, 1'b1, VERDICT_ACCEPT,    16'h4800},
    {8'd100, 8'h01, 8'd80,   16'd63,   1'b1, 1'b1, VERDICT_BAD_LEN,   16'h4F00},
    {8'd100, 8'h01, 8'd86,   16'd1523, 1'b1, 1'b1, VERDICT_BAD_LEN,   16'h5000},
    {8'd100, 8'h01, 8'd87,   16'd0,    1'b1, 1'b1, VERDICT_BAD_LEN,   16'h5600},
    {8'd0,   8'h01, 8'hFF,   16'hFFFF, 1'b1, 1'b1, VERDICT_PTR_ERR,   16'h5700},
    {8'd200, 8'h00, 8'd71,   16'd100,  1'b1, 1'b1, VERDICT_BAD_STAT,  16'h4600},
    // next page at ring stop wraps to start
    {8'd100, 8'h0F, 8'd128,  16'h3800, 1'b1, 1'b0, VERDICT_EMPTY,     16'h0000},
    // next page one ring length back
    {8'd100, 8'h01, 8'd71,   16'h3A00, 1'b1, 1'b0, VERDICT_EMPTY,     16'h0000},
    {8'd100, 8'h01, 8'd73,   16'h3A40, 1'b1, 1'b0, VERDICT_EMPTY,     16'h0000},
    {8'd255, 8'hFF, 8'd0,    16'hFFFF, 1'b1, 1'b1, VERDICT_PTR_ERR,   16'h4900},
    {8'd100, 8'h11, 8'd75,   16'd1000, 1'b0, 1'b1, VERDICT_NO_BUFFER, 16'h4600},
    // bad pointer wins over bad status
    {8'd90,  8'h02, 8'd90,   16'd1522, 1'b1, 1'b1, VERDICT_PTR_ERR,   16'h4B00},
    {8'd90,  8'hFF, 8'hFF,   16'hFFFF, 1'b1, 1'b1, VERDICT_EMPTY,     16'h5A00}
  };

  localparam logic [PAGE_W-1:0] PLAN_START [PHASES] = '{8'd0,   8'd240, 8'd255,
                                                        8'd10,  8'd0,   8'd70};
  localparam logic [PAGE_W-1:0] PLAN_STOP  [PHASES] = '{8'd255, 8'd255, 8'd1,
                                                        8'd0,   8'd1,   8'd128};

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  frame_in_t              item = '0;
  logic                   empty;
  logic                   pop = 1'b0;
  result_t                result;

  // predictor copy of the block
  logic [PAGE_W-1:0]  ring_start_q = RING_START_RESET;
  logic [PAGE_W-1:0]  ring_stop_q  = RING_STOP_RESET;
  logic [PAGE_W-1:0]  bnd_page     = BOUNDARY_RESET;
  logic [TOTAL_W-1:0] err_cnt  = '0;
  logic [TOTAL_W-1:0] pkt_cnt  = '0;
  logic [TOTAL_W-1:0] drop_cnt = '0;

  result_t verdict_q [$];
  int      mismatches = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  bit      hold_req = 1'b0;
  int      hold_left = 0;
  int      stuck = 0;

  always #2 clk = ~clk;

  rx_ring_frame_checker u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .full      (full),
    .item      (item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  function automatic logic [TOTAL_W-1:0] bump(input logic [TOTAL_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic int frame_page();
    int fp;
    fp = int'(bnd_page) + 1;
    if (fp >= int'(ring_stop_q)) fp = int'(ring_start_q);
    return fp;
  endfunction

  // consumes one frame: updates boundary and counters, returns the verdict record
  function automatic result_t judge_frame(input frame_in_t f);
    int      fp;
    int      npages;
    int      exp_pg;
    int      nxt;
    int      plen;
    result_t r;
    r = '0;
    plen = 0;
    fp = frame_page();
    if (fp == int'(f.write_page)) begin
      r.verdict = VERDICT_EMPTY;
    end else begin
      npages = int'(ring_stop_q) - int'(ring_start_q);
      exp_pg = fp + 1 + int'(f.hdr_count >> PAGE_W);
      plen = int'(f.hdr_count) - int'(HDR_BYTES);
      nxt = int'(f.hdr_next);
      if (nxt != exp_pg && nxt != exp_pg + 1 &&
          nxt != exp_pg - npages && nxt != exp_pg + 1 - npages) begin
        r.verdict = VERDICT_PTR_ERR;
        bnd_page = f.write_page - 8'd1;
        err_cnt = bump(err_cnt);
      end else begin
        if (plen < int'(MIN_PAYLOAD) || plen > int'(MAX_PAYLOAD)) begin
          r.verdict = VERDICT_BAD_LEN;
          err_cnt = bump(err_cnt);
        end else if ((f.hdr_status & STATUS_MASK) == STATUS_OK) begin
          if (f.host_buffer_free) begin
            r.verdict = VERDICT_ACCEPT;
            pkt_cnt = bump(pkt_cnt);
          end else begin
            r.verdict = VERDICT_NO_BUFFER;
            drop_cnt = bump(drop_cnt);
          end
        end else begin
          r.verdict = VERDICT_BAD_STAT;
          err_cnt = bump(err_cnt);
        end
        if (nxt >= int'(ring_stop_q)) nxt = int'(ring_start_q);
        bnd_page = 8'(nxt - 1);
      end
      if (plen < 0) plen = 0;
    end
    r.frame_offset = 16'(fp << PAGE_W);
    r.payload_len  = 16'(plen);
    r.new_boundary = bnd_page;
    r.error_total  = err_cnt;
    r.packet_total = pkt_cnt;
    r.drop_total   = drop_cnt;
    return r;
  endfunction

  // mostly well-formed headers for the current frame page, some empty rings, some noise
  function automatic frame_in_t make_frame();
    frame_in_t f;
    int        pick;
    int        fp;
    int        exp_pg;
    int        npages;
    int        nxt;
    f.write_page       = 8'($urandom);
    f.hdr_status       = 8'($urandom);
    f.hdr_next         = 8'($urandom);
    f.hdr_count        = 16'($urandom);
    f.host_buffer_free = 1'($urandom);
    pick = $urandom_range(99);
    if (pick < 20) return f;
    fp = frame_page();
    if (pick < 30) begin
      f.write_page = 8'(fp);
      return f;
    end
    if (f.write_page == 8'(fp)) f.write_page = f.write_page + 8'd1;
    case ($urandom_range(9))
      0: ;
      1: f.hdr_count = 16'($urandom_range(63));
      2: f.hdr_count = 16'($urandom_range(4000, 1523));
      default: f.hdr_count = 16'($urandom_range(1522, 64));
    endcase
    npages = int'(ring_stop_q) - int'(ring_start_q);
    exp_pg = fp + 1 + int'(f.hdr_count >> PAGE_W);
    case ($urandom_range(3))
      0: nxt = exp_pg;
      1: nxt = exp_pg + 1;
      2: nxt = exp_pg - npages;
      default: nxt = exp_pg + 1 - npages;
    endcase
    f.hdr_next = 8'(nxt);
    if ($urandom_range(4) != 0) f.hdr_status[3:0] = STATUS_OK[3:0];
    return f;
  endfunction

  task automatic send_frame(input frame_in_t f, input logic pin, input verdict_t pin_v,
                            input logic [COUNT_W-1:0] pin_ofs);
    result_t want;
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    push <= 1'b1;
    item <= f;
    @(posedge clk);
    while (full) @(posedge clk);
    // transfer happened at this edge
    want = judge_frame(f);
    if (pin) begin
      want.verdict = pin_v;
      want.frame_offset = pin_ofs;
    end
    verdict_q.push_back(want);
  endtask

  // leaves cfg_write high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    if (idx == CFG_RING_START) ring_start_q = d;
    else if (idx == CFG_RING_STOP) ring_stop_q = d;
  endtask

  task automatic load_ring(input logic [PAGE_W-1:0] start, input logic [PAGE_W-1:0] stop,
                           input bit spare);
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    write_reg(CFG_RING_START, start);
    write_reg(CFG_RING_STOP, stop);
    if (spare) begin
      write_reg(CFG_SPARE_2, 8'hFF);
      write_reg(CFG_SPARE_3, 8'h00);
    end
    cfg_write <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [TOTAL_W-1:0] want,
                             input logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input result_t got);
    result_t want;
    if (verdict_q.size() == 0) begin
      $display("%0t: result with nothing expected: expected none, got %h", $time, got);
      mismatches++;
      return;
    end
    want = verdict_q.pop_front();
    check_field("verdict", TOTAL_W'(want.verdict), TOTAL_W'(got.verdict));
    check_field("frame_offset", TOTAL_W'(want.frame_offset), TOTAL_W'(got.frame_offset));
    check_field("payload_len", TOTAL_W'(want.payload_len), TOTAL_W'(got.payload_len));
    check_field("new_boundary", TOTAL_W'(want.new_boundary), TOTAL_W'(got.new_boundary));
    check_field("error_total", want.error_total, got.error_total);
    check_field("packet_total", want.packet_total, got.packet_total);
    check_field("drop_total", want.drop_total, got.drop_total);
  endtask

  // result side: checks each transfer, random pop, long hold on request
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) check_result(result);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) stuck = 0;
      else stuck++;
      if (stuck >= STUCK_LIMIT) begin
        $display("rx_ring_frame_checker_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    int k;
    k = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 30;
    recv_idle_pct = 48;
    for (int i = 0; i < 16; i++)
      send_frame(DIR_TAB[i].hdr, DIR_TAB[i].pinned, DIR_TAB[i].verdict, DIR_TAB[i].offset);
    for (int ph = 0; ph < PHASES; ph++) begin
      load_ring(PLAN_START[ph], PLAN_STOP[ph], ph == 0);
      repeat (PHASE_ITEMS) begin
        if (k == 150) begin
          send_idle_pct = 48;
          recv_idle_pct = 30;
        end else if (k == 300) begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        // stall the result side while items keep coming, to fill the queue
        if (k == 40) hold_req = 1'b1;
        send_frame(make_frame(), 1'b0, VERDICT_EMPTY, '0);
        k++;
      end
    end
    push <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("rx_ring_frame_checker_tb: PASS");
    end else begin
      $display("rx_ring_frame_checker_tb: FAIL");
    end
    $finish;
  end

endmodule
